[rtl/core/frame_pacing_gate_defines.svh]
// Assertion macros used by the frame pacing gate datapath.
`ifndef FRAME_PACING_GATE_DEFINES_SVH
`define FRAME_PACING_GATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fpg_pkg.sv]
`default_nettype none

package fpg_pkg;

    // Fixed sizes of the block.
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SCALE_W    = 20;
    localparam int ACC_W      = 21;
    localparam int SEQ_W      = 63;
    localparam int PEND_W     = 9;
    localparam int CRED_W     = 16;
    localparam int REV_W      = 32;
    localparam int FRAMES_W   = 9;
    localparam int ERR_W      = 3;
    localparam int CMD_W      = 3;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 128;

    // Behavioural limits.
    localparam logic [6:0]         MAX_CONTROLLERS = 7'd8;
    localparam logic [SCALE_W-1:0] SCALE_ONE       = 20'd1000000;
    localparam logic [CRED_W-1:0]  MAX_STEPS       = 16'd256;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUEUE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd4;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_INVALID   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_LIMIT     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NOT_ZERO  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_FULL      = 3'd4;
    localparam logic [ERR_W-1:0] ERR_EXHAUSTED = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic scan_step;
        logic apply;
        logic load_out;
    } fpg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } fpg_stat_t;

    // Revision increment that never lands on zero.
    function automatic logic [REV_W-1:0] bump_rev(input logic [REV_W-1:0] r);
        bump_rev = (r == {REV_W{1'b1}}) ? {{(REV_W-1){1'b0}}, 1'b1} : r + 1'b1;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fpg_ctrl.sv]
`default_nettype none

module fpg_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire fpg_pkg::fpg_stat_t stat,
    output fpg_pkg::fpg_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_full_reg, out_full_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_full_reg;

    // Sequencing of one item through execute, optional scan and apply, and result load.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.need_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_full_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register is full from load until the item is taken.
    always_comb begin
        out_full_next = out_full_reg;
        if (cmd.load_out) begin
            out_full_next = 1'b1;
        end else if (m_tready) begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fpg_datapath.sv]
`default_nettype none
`include "frame_pacing_gate_defines.svh"

module fpg_datapath #(
    parameter logic [6:0]                  MAX_CONTROLLERS = fpg_pkg::MAX_CONTROLLERS,
    parameter logic [fpg_pkg::SCALE_W-1:0] SCALE_ONE       = fpg_pkg::SCALE_ONE,
    parameter logic [fpg_pkg::CRED_W-1:0]  MAX_STEPS       = fpg_pkg::MAX_STEPS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [fpg_pkg::IN_W-1:0]    s_tdata,
    output logic      [fpg_pkg::OUT_W-1:0]   m_tdata,
    input  wire fpg_pkg::fpg_cmd_t           cmd,
    output fpg_pkg::fpg_stat_t               stat
);

    localparam int SUM_W = fpg_pkg::CRED_W + 1;

    // Latched input item.
    logic [fpg_pkg::CMD_W-1:0]    op_reg;
    logic [fpg_pkg::SLOT_W-1:0]   slot_reg;
    logic [fpg_pkg::SCALE_W-1:0]  req_reg;
    logic [fpg_pkg::FRAMES_W-1:0] frames_reg;
    logic                         pause_reg;

    // Block state.
    logic [fpg_pkg::SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [fpg_pkg::SCALE_W-1:0]    slot_scale_reg [fpg_pkg::SLOT_COUNT];
    logic [fpg_pkg::SCALE_W-1:0]    scale_reg, scale_next;
    logic [fpg_pkg::REV_W-1:0]      revision_reg, revision_next;
    logic [fpg_pkg::SEQ_W-1:0]      seq_reg, seq_next;
    logic [fpg_pkg::CRED_W-1:0]     pending_reg, pending_next;
    logic [fpg_pkg::ACC_W-1:0]      acc_reg, acc_next;

    // Per-item working registers.
    logic                         adv_reg, adv_next;
    logic [fpg_pkg::ERR_W-1:0]    err_reg, err_next;
    logic [fpg_pkg::SLOT_W-1:0]   idx_reg, idx_next;
    logic [fpg_pkg::SCALE_W-1:0]  min_reg, min_next;
    logic [fpg_pkg::OUT_W-1:0]    out_reg;

    logic                         wr_en;
    logic [fpg_pkg::SLOT_W-1:0]   rd_addr;
    logic [fpg_pkg::SCALE_W-1:0]  rd_scale;
    logic                         slot_valid;
    logic [6:0]                   held_cnt;
    logic                         at_limit;
    logic [21:0]                  acc_add;
    logic [SUM_W-1:0]             pend_sum;
    logic [fpg_pkg::SEQ_W:0]      seq_sum;
    logic                         bad_frames;
    logic                         not_holder;

    // One read port on the slot scales: the scan index while scanning, else the slot.
    assign rd_addr    = cmd.scan_step ? idx_reg : slot_reg;
    assign rd_scale   = slot_scale_reg[rd_addr];
    assign slot_valid = valid_reg[slot_reg];
    assign held_cnt   = 7'($countones(valid_reg));
    assign at_limit   = !slot_valid && (held_cnt >= MAX_CONTROLLERS);

    // Arithmetic for tick and queue checks.
    assign acc_add    = 22'(acc_reg) + 22'(scale_reg);
    assign pend_sum   = SUM_W'(pending_reg) + SUM_W'(frames_reg);
    assign seq_sum    = {1'b0, seq_reg} + 64'(frames_reg);
    assign bad_frames = (frames_reg == '0) ||
                        (fpg_pkg::CRED_W'(frames_reg) > MAX_STEPS);
    assign not_holder = (scale_reg != '0) || !slot_valid || (rd_scale != '0);

    // A set that is taken below full scale, or a release or clear of a held slot, needs a fresh minimum.
    always_comb begin
        stat.scan_last = (idx_reg == fpg_pkg::SLOT_W'(fpg_pkg::SLOT_COUNT - 1));
        stat.need_scan = 1'b0;
        case (op_reg)
            fpg_pkg::CMD_SET: begin
                if (req_reg == SCALE_ONE) begin
                    stat.need_scan = slot_valid;
                end else if (req_reg < SCALE_ONE) begin
                    stat.need_scan = !at_limit;
                end
            end
            fpg_pkg::CMD_CLEAR: begin
                stat.need_scan = slot_valid;
            end
            default: begin
                stat.need_scan = 1'b0;
            end
        endcase
    end

    // Execute, scan and apply steps.
    always_comb begin
        valid_next    = valid_reg;
        scale_next    = scale_reg;
        revision_next = revision_reg;
        seq_next      = seq_reg;
        pending_next  = pending_reg;
        acc_next      = acc_reg;
        adv_next      = adv_reg;
        err_next      = err_reg;
        idx_next      = idx_reg;
        min_next      = min_reg;
        wr_en         = 1'b0;

        if (cmd.exec) begin
            adv_next = 1'b0;
            err_next = fpg_pkg::ERR_OK;
            idx_next = '0;
            min_next = SCALE_ONE;
            case (op_reg)
                fpg_pkg::CMD_TICK: begin
                    if (pause_reg) begin
                        adv_next = 1'b0;
                    end else if (scale_reg == SCALE_ONE) begin
                        adv_next = 1'b1;
                    end else if (scale_reg == '0) begin
                        if (pending_reg != '0) begin
                            pending_next = pending_reg - 1'b1;
                            adv_next     = 1'b1;
                        end
                    end else if (acc_add >= 22'(SCALE_ONE)) begin
                        acc_next = fpg_pkg::ACC_W'(acc_add - 22'(SCALE_ONE));
                        adv_next = 1'b1;
                    end else begin
                        acc_next = fpg_pkg::ACC_W'(acc_add);
                    end
                end
                fpg_pkg::CMD_SET: begin
                    if (req_reg > SCALE_ONE) begin
                        err_next = fpg_pkg::ERR_INVALID;
                    end else if (req_reg == SCALE_ONE) begin
                        valid_next[slot_reg] = 1'b0;
                    end else if (at_limit) begin
                        err_next = fpg_pkg::ERR_LIMIT;
                    end else begin
                        valid_next[slot_reg] = 1'b1;
                        wr_en                = 1'b1;
                    end
                end
                fpg_pkg::CMD_CLEAR: begin
                    valid_next[slot_reg] = 1'b0;
                end
                fpg_pkg::CMD_QUEUE: begin
                    if (bad_frames) begin
                        err_next = fpg_pkg::ERR_INVALID;
                    end else if (not_holder) begin
                        err_next = fpg_pkg::ERR_NOT_ZERO;
                    end else if (pend_sum > SUM_W'(MAX_STEPS)) begin
                        err_next = fpg_pkg::ERR_FULL;
                    end else if (seq_sum[fpg_pkg::SEQ_W]) begin
                        err_next = fpg_pkg::ERR_EXHAUSTED;
                    end else begin
                        seq_next      = seq_sum[fpg_pkg::SEQ_W-1:0];
                        pending_next  = pend_sum[fpg_pkg::CRED_W-1:0];
                        revision_next = fpg_pkg::bump_rev(revision_reg);
                    end
                end
                fpg_pkg::CMD_RESET: begin
                    valid_next    = '0;
                    scale_next    = SCALE_ONE;
                    seq_next      = '0;
                    pending_next  = '0;
                    acc_next      = '0;
                    revision_next = fpg_pkg::bump_rev(revision_reg);
                end
                default: begin
                    err_next = fpg_pkg::ERR_INVALID;
                end
            endcase
        end

        // Serial minimum over the held slots, one slot a cycle.
        if (cmd.scan_step) begin
            if (valid_reg[idx_reg] && (rd_scale < min_reg)) begin
                min_next = rd_scale;
            end
            idx_next = idx_reg + 1'b1;
        end

        // Take the new minimum if it differs from the current scale.
        if (cmd.apply && (min_reg != scale_reg)) begin
            scale_next    = min_reg;
            revision_next = fpg_pkg::bump_rev(revision_reg);
            if (min_reg != '0) begin
                pending_next = '0;
            end
            if ((min_reg == '0) || (min_reg == SCALE_ONE)) begin
                acc_next = '0;
            end else begin
                acc_next = fpg_pkg::ACC_W'(SCALE_ONE - min_reg);
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            scale_reg    <= SCALE_ONE;
            revision_reg <= fpg_pkg::REV_W'(1);
            seq_reg      <= '0;
            pending_reg  <= '0;
            acc_reg      <= '0;
            idx_reg      <= '0;
        end else begin
            valid_reg    <= valid_next;
            scale_reg    <= scale_next;
            revision_reg <= revision_next;
            seq_reg      <= seq_next;
            pending_reg  <= pending_next;
            acc_reg      <= acc_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload registers: input latch, slot scales, working values, result.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg     <= s_tdata[2:0];
            slot_reg   <= s_tdata[5:3];
            req_reg    <= s_tdata[25:6];
            frames_reg <= s_tdata[34:26];
            pause_reg  <= s_tdata[35];
        end
        if (wr_en) begin
            slot_scale_reg[slot_reg] <= req_reg;
        end
        adv_reg <= adv_next;
        err_reg <= err_next;
        min_reg <= min_next;
        if (cmd.load_out) begin
            out_reg <= {revision_reg, pending_reg[fpg_pkg::PEND_W-1:0], seq_reg, scale_reg,
                        err_reg, adv_reg};
        end
    end

    assign m_tdata = out_reg;

    `FPG_ASSERT_NOW(a_pending_bound, aclk, aresetn, cmd.load_out, (pending_reg <= MAX_STEPS), "pending credits above the step limit")
    `FPG_ASSERT_NOW(a_scan_wrapped, aclk, aresetn, cmd.apply, (idx_reg == '0), "slot scan did not cover every slot")
    `FPG_ASSERT_NOW(a_acc_idle, aclk, aresetn, ((scale_reg == '0) || (scale_reg == SCALE_ONE)), (acc_reg == '0), "accumulator not clear at a whole scale")
    `FPG_ASSERT_NEXT(a_rev_stable, aclk, aresetn, (!cmd.exec && !cmd.apply), $stable(revision_reg), "revision moved outside execute or apply")

endmodule

`default_nettype wire

[rtl/core/frame_pacing_gate.sv]
`default_nettype none

// Channel | Direction | tdata fields (lowest bit first)
// s_      | in        | command 3, controller 3, scale_request 20, step frames 9,
//         |           | external_pause 1, zero fill 4 (40 bits)
// m_      | out       | advance 1, error_code 3, effective_scale 20, step_count 63,
//         |           | queued credits 9, revision_out 32 (128 bits)
//
// A tick, queue, reset run, rejected set or release of an empty slot passes through
// accept, execute and result load. A set that is taken, or the release of a held slot,
// also runs the serial minimum scan over the eight requester slots (one slot a cycle)
// and an apply step before the result load.
// Reset (aresetn low, synchronous) clears all requests and the output full flag.
// A new item is accepted while a finished result still waits on m_; the block stalls
// only when a second result is ready before the first is taken.

module frame_pacing_gate #(
    parameter logic [6:0]                  MAX_CONTROLLERS = fpg_pkg::MAX_CONTROLLERS,
    parameter logic [fpg_pkg::SCALE_W-1:0] SCALE_ONE       = fpg_pkg::SCALE_ONE,
    parameter logic [fpg_pkg::CRED_W-1:0]  MAX_STEPS       = fpg_pkg::MAX_STEPS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // command, controller, scale_request, step frames, external_pause, zero fill
    input  wire logic [fpg_pkg::IN_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // advance, error_code, effective_scale, step_count, queued credits, revision_out
    output logic      [fpg_pkg::OUT_W-1:0]  m_tdata
);

    fpg_pkg::fpg_cmd_t  cmd;
    fpg_pkg::fpg_stat_t stat;

    // Sequencer.
    fpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // State, arithmetic and result register.
    fpg_datapath #(
        .MAX_CONTROLLERS (MAX_CONTROLLERS),
        .SCALE_ONE       (SCALE_ONE),
        .MAX_STEPS       (MAX_STEPS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire
